@@ hdl/tt_pkg.sv @@
`default_nettype none

package tt_pkg;

  // Command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_REFRESH = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ADD       = 2'd0,
    KIND_UPDATE    = 2'd1,
    KIND_EXPIRED   = 2'd2,
    KIND_TICK_DONE = 2'd3
  } kind_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_FIN
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [23:0] duration;
    logic [31:0] handle;
    logic        notify;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] result_handle;
    logic        status;
    logic        last;
  } rsp_t;

  // One table entry as stored in the slot RAM
  typedef struct packed {
    logic [31:0] handle;
    logic [23:0] duration;
    logic [23:0] remaining;
    logic        notify;
  } entry_t;

  // Verdict of the slot evaluator on one entry
  typedef struct packed {
    logic   match;
    logic   expired;
    entry_t aged;
    entry_t reloaded;
  } eval_t;

endpackage

`default_nettype wire

@@ hdl/tt_ram.sv @@
`default_nettype none

module tt_ram #(
  parameter int WIDTH = 81,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/tt_slot_eval.sv @@
`default_nettype none

module tt_slot_eval (
  input  wire tt_pkg::entry_t entry,
  input  wire logic [31:0]    key,
  output tt_pkg::eval_t       ev
);

  // Handle compare, zero test and countdown for the slot under scan
  always_comb begin
    ev.match              = (entry.handle == key);
    ev.expired            = (entry.remaining == 24'd0);
    ev.aged               = entry;
    ev.aged.remaining     = entry.remaining - 24'd1;
    ev.reloaded           = entry;
    ev.reloaded.remaining = entry.duration;
  end

endmodule

`default_nettype wire

@@ hdl/timeout_table_core.sv @@
`default_nettype none

// Ordered table of up to SLOTS countdown timeouts, kept packed in a slot RAM with
// one write port and one registered read port. A transaction is taken when start
// is high and busy is low. Add finishes in the accepting cycle and busy stays low.
// Refresh, remove and tick scan the occupied slots one at a time through one shared
// slot evaluator: each slot passes a RAM read state, then an evaluate and write-back
// state; the scan closes with a last read state and a finish state, with busy high
// throughout (a refresh stops at its first match). Results come one per strobe
// cycle, in the cycle after they are formed; the receiver cannot stall and must
// take every result in the cycle it is shown. A tick gives one expired-entry
// result per expiring entry with notify set, then a tick-done result with last set.
module timeout_table_core #(
  parameter int SLOTS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire tt_pkg::req_t req,
  output logic              busy,
  output logic              strobe,
  output tt_pkg::rsp_t      rsp
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = $bits(tt_pkg::entry_t);

  tt_pkg::state_e state, state_next;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] w, w_next;
  logic          found, found_next;
  logic [31:0]   next_handle, next_handle_next;

  tt_pkg::cmd_e  cmd_r;
  logic [31:0]   hnd_r;
  logic          latch;

  logic           we;
  logic [IW-1:0]  waddr;
  tt_pkg::entry_t wdata;
  logic [EW-1:0]  ram_rdata;
  tt_pkg::entry_t rd_entry;
  tt_pkg::eval_t  ev;

  logic         emit;
  tt_pkg::rsp_t emit_rsp;

  // Slot storage
  tt_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (i[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_entry = tt_pkg::entry_t'(ram_rdata);

  // Shared evaluator for the slot just read
  tt_slot_eval u_eval (
    .entry (rd_entry),
    .key   (hnd_r),
    .ev    (ev)
  );

  assign busy = (state != tt_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tt_pkg::S_IDLE: begin
        if (start && (req.cmd != tt_pkg::CMD_ADD)) state_next = tt_pkg::S_RD;
      end
      tt_pkg::S_RD: begin
        state_next = (i == count) ? tt_pkg::S_FIN : tt_pkg::S_EV;
      end
      tt_pkg::S_EV: begin
        if ((cmd_r == tt_pkg::CMD_REFRESH) && ev.match) state_next = tt_pkg::S_FIN;
        else state_next = tt_pkg::S_RD;
      end
      tt_pkg::S_FIN: state_next = tt_pkg::S_IDLE;
      default:       state_next = tt_pkg::S_IDLE;
    endcase
  end

  // Datapath control and results
  always_comb begin
    latch            = 1'b0;
    we               = 1'b0;
    waddr            = w[IW-1:0];
    wdata            = ev.aged;
    emit             = 1'b0;
    emit_rsp         = '0;
    i_next           = i;
    w_next           = w;
    found_next       = found;
    count_next       = count;
    next_handle_next = next_handle;
    case (state)
      tt_pkg::S_IDLE: begin
        if (start) begin
          latch      = 1'b1;
          i_next     = '0;
          w_next     = '0;
          found_next = 1'b0;
          if (req.cmd == tt_pkg::CMD_ADD) begin
            emit          = 1'b1;
            emit_rsp.kind = tt_pkg::KIND_ADD;
            emit_rsp.last = 1'b1;
            if (count == CW'(SLOTS)) begin
              emit_rsp.status = 1'b1;
            end else begin
              we                     = 1'b1;
              waddr                  = count[IW-1:0];
              wdata.handle           = next_handle;
              wdata.duration         = req.duration;
              wdata.remaining        = req.duration;
              wdata.notify           = req.notify;
              emit_rsp.result_handle = next_handle;
              count_next             = count + CW'(1);
              next_handle_next       = next_handle + 32'd1;
            end
          end
        end
      end
      tt_pkg::S_RD: begin
        // read of slot i is in flight
      end
      tt_pkg::S_EV: begin
        i_next = i + CW'(1);
        case (cmd_r)
          tt_pkg::CMD_TICK: begin
            if (ev.expired) begin
              if (rd_entry.notify) begin
                emit                   = 1'b1;
                emit_rsp.kind          = tt_pkg::KIND_EXPIRED;
                emit_rsp.result_handle = rd_entry.handle;
              end
            end else begin
              // survivor moves down to the compaction point
              we     = 1'b1;
              wdata  = ev.aged;
              w_next = w + CW'(1);
            end
          end
          tt_pkg::CMD_REFRESH: begin
            if (ev.match) begin
              we         = 1'b1;
              waddr      = i[IW-1:0];
              wdata      = ev.reloaded;
              found_next = 1'b1;
            end
          end
          tt_pkg::CMD_REMOVE: begin
            if (found) begin
              // close the gap left by the removed entry
              we     = 1'b1;
              wdata  = rd_entry;
              w_next = w + CW'(1);
            end else if (ev.match) begin
              found_next = 1'b1;
            end else begin
              w_next = w + CW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      tt_pkg::S_FIN: begin
        emit          = 1'b1;
        emit_rsp.last = 1'b1;
        if (cmd_r == tt_pkg::CMD_TICK) begin
          emit_rsp.kind = tt_pkg::KIND_TICK_DONE;
          count_next    = w;
        end else begin
          emit_rsp.kind          = tt_pkg::KIND_UPDATE;
          emit_rsp.result_handle = hnd_r;
          emit_rsp.status        = ~found;
          if ((cmd_r == tt_pkg::CMD_REMOVE) && found) count_next = w;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tt_pkg::S_IDLE;
      count       <= '0;
      i           <= '0;
      w           <= '0;
      found       <= 1'b0;
      next_handle <= '0;
      strobe      <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      i           <= i_next;
      w           <= w_next;
      found       <= found_next;
      next_handle <= next_handle_next;
      strobe      <= emit;
    end
  end

  // Transaction fields and result register
  always_ff @(posedge clk) begin
    if (latch) begin
      cmd_r <= req.cmd;
      hnd_r <= req.handle;
    end
    if (emit) begin
      rsp <= emit_rsp;
    end
  end

  // Only expired-entry results may be followed by more results
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (strobe && !rsp.last) |-> (rsp.kind == tt_pkg::KIND_EXPIRED))
    else $error("non-final result of wrong kind");

  // Occupancy stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SLOTS))
    else $error("entry count beyond table size");

  // Compaction point never passes the scan point, scan never passes the end
  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (state != tt_pkg::S_IDLE) |-> ((w <= i) && (i <= count)))
    else $error("scan pointers out of order");

  // An add answers in the next cycle
  a_add_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.cmd == tt_pkg::CMD_ADD)) |=>
      (strobe && (rsp.kind == tt_pkg::KIND_ADD) && rsp.last))
    else $error("add result missing");

  // Scanning commands hold the block busy
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.cmd != tt_pkg::CMD_ADD)) |=> busy)
    else $error("scan command not started");

endmodule

`default_nettype wire
